FILE: rtl/planar_tile_band_to_raster_core_assert.svh
// Assertion macros shared by the planar tile band converter.
`ifndef PLANAR_TILE_BAND_TO_RASTER_CORE_ASSERT_SVH
`define PLANAR_TILE_BAND_TO_RASTER_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PTBR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ptbr: assertion failed");

// Check that a condition never holds outside reset.
`define PTBR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ptbr: forbidden condition seen");

`endif

FILE: rtl/ptbr_pkg.sv
// -----------------------------------------------------------------------------
// ptbr_pkg
// Types and constants for the planar tile band to raster converter.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptbr_pkg;

  // Default geometry
  localparam int TILES_ACROSS_DEF      = 16;
  localparam int PIXELS_PER_RESULT_DEF = 32;

  // Fixed tile layout: 8 low-plane rows then 8 high-plane rows
  localparam int TILE_BYTES = 16;
  localparam int PLANE_ROWS = 8;
  localparam int GROUP_BITS = 64;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_in_t;

  // Result item
  typedef struct packed {
    logic [GROUP_BITS-1:0] pixel_group;
    logic [2:0]            row_in_band;
    logic [1:0]            group_in_row;
    logic                  band_done;
    logic                  image_done;
  } item_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr;          // store the accepted byte
    logic begin_band;  // latch end flag, clear walk counters
    logic rd_hi;       // read address selects the high plane
    logic cap_lo;      // capture low-plane byte
    logic merge;       // merge tile row into the group accumulator
    logic flush;       // emit the padded remainder of a row
    logic band_end;    // band finished, clear the fill count
  } ptbr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fill_last;   // next byte fills the band
    logic last_tile;   // walk is on the last tile of the row
    logic last_row;    // walk is on the last row of the band
    logic pend_rem;    // pixels remain in the accumulator after the merge
  } ptbr_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ptbr_ctrl.sv
// -----------------------------------------------------------------------------
// ptbr_ctrl
// Sequencer: takes bytes while idle, then walks the band tile by tile,
// row by row, issuing reads, merges and row flushes to the datapath.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptbr_ctrl import ptbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       end_of_data_i,
  input  ptbr_stat_t stat_i,
  output logic       busy,
  output ptbr_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD_LO = 3'd1;
  localparam logic [2:0] S_RD_HI = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.wr = 1'b1;
          if (stat_i.fill_last || end_of_data_i) begin
            cmd_o.begin_band = 1'b1;
            state_d          = S_RD_LO;
          end
        end
      end
      S_RD_LO: begin
        state_d = S_RD_HI;
      end
      S_RD_HI: begin
        cmd_o.rd_hi  = 1'b1;
        cmd_o.cap_lo = 1'b1;
        state_d      = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        if (!stat_i.last_tile) begin
          state_d = S_RD_LO;
        end else if (stat_i.pend_rem) begin
          state_d = S_FLUSH;
        end else if (stat_i.last_row) begin
          cmd_o.band_end = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_RD_LO;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (stat_i.last_row) begin
          cmd_o.band_end = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_RD_LO;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/ptbr_datapath.sv
// -----------------------------------------------------------------------------
// ptbr_datapath
// Band store, fill count, tile walk counters and the group accumulator
// that packs 8-pixel tile rows into fixed-size pixel groups.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "planar_tile_band_to_raster_core_assert.svh"

module ptbr_datapath import ptbr_pkg::*; #(
  parameter int TILES_ACROSS      = TILES_ACROSS_DEF,
  parameter int PIXELS_PER_RESULT = PIXELS_PER_RESULT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ptbr_cmd_t  cmd_i,
  input  item_in_t   item_i,
  output ptbr_stat_t stat_o,
  output logic       result_valid_o,
  output item_out_t  result_o
);

  localparam int BAND_BYTES = TILES_ACROSS * TILE_BYTES;
  localparam int ADDR_W     = $clog2(BAND_BYTES);
  localparam int FILL_W     = $clog2(BAND_BYTES + 1);
  localparam int TILE_W     = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
  localparam int ROW_PIXELS = TILES_ACROSS * PLANE_ROWS;
  localparam int GROUPS     = (ROW_PIXELS + PIXELS_PER_RESULT - 1) / PIXELS_PER_RESULT;
  localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PIX_BITS   = 2 * PIXELS_PER_RESULT;
  localparam int ACC_W      = 2 * (PIXELS_PER_RESULT + PLANE_ROWS);
  localparam int K_W        = $clog2(PIXELS_PER_RESULT + PLANE_ROWS);

  logic [7:0]        mem [BAND_BYTES];
  logic [7:0]        rdata_q;
  logic              rd_ok_q;
  logic [FILL_W-1:0] fill_q;
  logic              last_q;
  logic [TILE_W-1:0] tile_q;
  logic [2:0]        row_q;
  logic [GRP_W-1:0]  grp_q;
  logic [K_W-1:0]    k_q;
  logic [ACC_W-1:0]  acc_q;
  logic [7:0]        lo_q;
  logic              result_valid_q;
  item_out_t         result_q;

  logic [TILE_W+3:0]   rd_addr_full;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_ok;
  logic [7:0]          byte_val;
  logic [15:0]         tile_pix;
  logic [ACC_W-1:0]    merged;
  logic [K_W-1:0]      k_sum;
  logic                emit_full;
  logic [K_W-1:0]      k_after;
  logic [ACC_W-1:0]    acc_after;
  logic                last_tile;
  logic                emit;
  logic [PIX_BITS-1:0] emit_bits;
  logic                band_final;

  // Byte address: tile * 16 + plane * 8 + row
  assign rd_addr_full = {tile_q, cmd_i.rd_hi, row_q};
  assign rd_addr      = rd_addr_full[ADDR_W-1:0];
  assign rd_ok        = (FILL_W'(rd_addr) < fill_q);

  // Band store: write at the fill position, read for the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[fill_q[ADDR_W-1:0]] <= item_i.data_byte;
    end
    rdata_q <= mem[rd_addr];
    rd_ok_q <= rd_ok;
  end

  // Drop bytes past the received data
  assign byte_val = rd_ok_q ? rdata_q : 8'h00;

  // Interleave planes, leftmost pixel (MSB) into the lowest pixel slot
  always_comb begin
    for (int j = 0; j < PLANE_ROWS; j++) begin
      tile_pix[2*j]   = lo_q[7-j];
      tile_pix[2*j+1] = byte_val[7-j];
    end
  end

  // Append eight pixels above the k pixels already held
  assign merged    = acc_q | (ACC_W'(tile_pix) << {k_q, 1'b0});
  assign k_sum     = k_q + K_W'(PLANE_ROWS);
  assign emit_full = (k_sum >= K_W'(PIXELS_PER_RESULT));
  assign k_after   = emit_full ? (k_sum - K_W'(PIXELS_PER_RESULT)) : k_sum;
  assign acc_after = emit_full ? (merged >> PIX_BITS) : merged;
  assign last_tile = (tile_q == TILE_W'(TILES_ACROSS - 1));

  assign emit       = (cmd_i.merge && emit_full) || cmd_i.flush;
  assign emit_bits  = cmd_i.flush ? acc_q[PIX_BITS-1:0] : merged[PIX_BITS-1:0];
  assign band_final = (row_q == 3'(PLANE_ROWS - 1)) && (grp_q == GRP_W'(GROUPS - 1));

  // Status to the controller
  always_comb begin
    stat_o.fill_last = (fill_q == FILL_W'(BAND_BYTES - 1));
    stat_o.last_tile = last_tile;
    stat_o.last_row  = (row_q == 3'(PLANE_ROWS - 1));
    stat_o.pend_rem  = (k_after != '0);
  end

  // Fill count, walk counters and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q         <= '0;
      last_q         <= 1'b0;
      tile_q         <= '0;
      row_q          <= '0;
      grp_q          <= '0;
      k_q            <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= emit;
      if (cmd_i.wr) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (cmd_i.band_end) begin
        fill_q <= '0;
      end
      if (cmd_i.begin_band) begin
        last_q <= item_i.end_of_data;
        tile_q <= '0;
        row_q  <= '0;
        grp_q  <= '0;
        k_q    <= '0;
      end else if (cmd_i.merge) begin
        k_q    <= k_after;
        tile_q <= last_tile ? '0 : tile_q + TILE_W'(1);
        if (last_tile && (k_after == '0)) begin
          row_q <= row_q + 3'd1;
          grp_q <= '0;
        end else if (emit_full) begin
          grp_q <= grp_q + GRP_W'(1);
        end
      end else if (cmd_i.flush) begin
        k_q   <= '0;
        row_q <= row_q + 3'd1;
        grp_q <= '0;
      end
    end
  end

  // Accumulator, low-plane hold and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_band || cmd_i.flush) begin
      acc_q <= '0;
    end else if (cmd_i.merge) begin
      acc_q <= acc_after;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= byte_val;
    end
    if (emit) begin
      result_q.pixel_group  <= GROUP_BITS'(emit_bits);
      result_q.row_in_band  <= row_q;
      result_q.group_in_row <= 2'(grp_q);
      result_q.band_done    <= band_final;
      result_q.image_done   <= band_final && last_q;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `PTBR_ASSERT(a_band_done_row, clk_i, rst_ni, (result_valid_o && result_o.band_done) |-> (result_o.row_in_band == 3'(PLANE_ROWS - 1)))
  `PTBR_ASSERT(a_image_in_band, clk_i, rst_ni, (result_valid_o && result_o.image_done) |-> result_o.band_done)
  `PTBR_ASSERT_NEVER(a_acc_count, clk_i, rst_ni, k_q >= K_W'(PIXELS_PER_RESULT))
  `PTBR_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > FILL_W'(BAND_BYTES))
  `PTBR_ASSERT(a_fill_cleared, clk_i, rst_ni, cmd_i.band_end |=> (fill_q == '0))

endmodule

`default_nettype wire

FILE: rtl/planar_tile_band_to_raster_core.sv
// Accepts one byte per cycle while idle; a byte that fills the band or carries end_of_data
// starts emission, and busy stays high until the last result is being issued.
// Emission walks 8 rows x TILES_ACROSS tiles; each tile takes two store reads and a merge on
// the single read port, and a row with a padded remainder adds a flush step.
// Results cannot be held off. Reset clears fill count and sequencer.
// -----------------------------------------------------------------------------
// planar_tile_band_to_raster_core
// Gathers 2bpp planar 8x8 tiles into a band and emits it as raster pixel groups.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module planar_tile_band_to_raster_core import ptbr_pkg::*; #(
  parameter int TILES_ACROSS      = TILES_ACROSS_DEF,
  parameter int PIXELS_PER_RESULT = PIXELS_PER_RESULT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  item_in_t  item_i,
  output logic      result_valid_o,
  output item_out_t result_o
);

  ptbr_cmd_t  cmd;
  ptbr_stat_t stat;

  // Sequencer
  ptbr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .end_of_data_i (item_i.end_of_data),
    .stat_i        (stat),
    .busy          (busy),
    .cmd_o         (cmd)
  );

  // Store, counters and pixel packing
  ptbr_datapath #(
    .TILES_ACROSS      (TILES_ACROSS),
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/planar_tile_band_to_raster_core_test.sv
// -----------------------------------------------------------------------------
// planar_tile_band_to_raster_core_test
// Drives planar 2bpp tile bytes into the band converter and checks every
// raster pixel group against an in-bench prediction of the band store.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module planar_tile_band_to_raster_core_test;
  import ptbr_pkg::*;

  localparam int TILES          = TILES_ACROSS_DEF;
  localparam int GROUP_PIXELS   = PIXELS_PER_RESULT_DEF;
  localparam int BAND_BYTES     = TILES * TILE_BYTES;
  localparam int ROW_PIXELS     = TILES * 8;
  localparam int GROUPS_PER_ROW = (ROW_PIXELS + GROUP_PIXELS - 1) / GROUP_PIXELS;
  localparam int STALL_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 50;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  item_in_t  item_i;
  logic      result_valid_o;
  item_out_t result_o;

  // Predicted band store and the raster groups still owed by the block
  logic [7:0]  band_bytes [BAND_BYTES];
  int unsigned band_fill;
  item_out_t   pending_groups [$];

  int unsigned idle_pct;
  int unsigned fail_count;
  int unsigned stall_cycles;

  planar_tile_band_to_raster_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Positions past the received bytes read as zero
  function automatic logic [7:0] held_byte(int unsigned pos);
    if (pos >= band_fill) return 8'h00;
    return band_bytes[pos];
  endfunction

  // Store one byte; on a full band or end of data queue the raster groups
  task automatic absorb_byte(input logic [7:0] b, input logic eod);
    item_out_t   res;
    logic [63:0] acc;
    logic [7:0]  lo_row;
    logic [7:0]  hi_row;
    int unsigned x;
    int unsigned sh;
    if (band_fill < BAND_BYTES) begin
      band_bytes[band_fill] = b;
      band_fill++;
    end
    if (band_fill >= BAND_BYTES || eod) begin
      for (int row = 0; row < PLANE_ROWS; row++) begin
        for (int grp = 0; grp < GROUPS_PER_ROW; grp++) begin
          acc = '0;
          for (int p = 0; p < GROUP_PIXELS; p++) begin
            x = grp * GROUP_PIXELS + p;
            if (x >= ROW_PIXELS) break;
            sh     = 7 - (x % 8);
            lo_row = held_byte((x / 8) * TILE_BYTES + row);
            hi_row = held_byte((x / 8) * TILE_BYTES + row + PLANE_ROWS);
            acc[2*p +: 2] = {hi_row[sh], lo_row[sh]};
          end
          res.pixel_group  = acc;
          res.row_in_band  = row[2:0];
          res.group_in_row = grp[1:0];
          res.band_done    = (row == PLANE_ROWS - 1) && (grp == GROUPS_PER_ROW - 1);
          res.image_done   = res.band_done && eod;
          pending_groups.push_back(res);
        end
      end
      band_fill = 0;
    end
  endtask

  // Offer one byte, idling at random first, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eod);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start  <= 1'b0;
      item_i <= item_in_t'(9'($urandom));
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{data_byte: b, end_of_data: eod};
    do @(posedge clk_i); while (busy);
    absorb_byte(b, eod);
  endtask

  // Hold off the sender until every owed group has come out
  task automatic drain_groups();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk_i);
  endtask

  // Send a band of random bytes, end of data on the last one if asked
  task automatic send_band(input int unsigned len, input logic eod_last);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), eod_last && (i == len - 1));
  endtask

  // Single-byte images: all ones and all zeros in the first low-plane row
  task automatic test_single_byte();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    drain_groups();
  endtask

  // Partial tile: whole low plane, one high-plane row, rest padded with zero
  task automatic test_partial_tile();
    logic [7:0] pattern [9] = '{8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0,
                                8'h0F, 8'hFF, 8'h00, 8'hC3};
    for (int i = 0; i < 9; i++) send_byte(pattern[i], i == 8);
    drain_groups();
  endtask

  // Two bytes short of a whole tile, then input after end of data
  task automatic test_tile_then_restart();
    for (int i = 0; i < 14; i++) send_byte(8'($urandom), i == 13);
    send_byte(8'hA5, 1'b1);
    drain_groups();
  endtask

  // Random bands, mostly short; some run on without end of data
  task automatic test_random_bands(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) len = $urandom_range(48, 17);
      else                        len = $urandom_range(16, 1);
      if (len > n_items - sent) len = n_items - sent;
      send_band(len, $urandom_range(5) != 0);
      sent += len;
      if ($urandom_range(3) == 0) drain_groups();
    end
    // Close any band left open so the phase ends clean
    send_byte(8'($urandom), 1'b1);
    drain_groups();
  endtask

  // Report one field that differs from the prediction
  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each group with the oldest prediction
  always @(posedge clk_i) begin
    item_out_t exp_g;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_groups.size() == 0) begin
        $display("%0t: unexpected group: expected none actual %h", $time, result_o);
        fail_count++;
      end else begin
        exp_g = pending_groups.pop_front();
        check_field("pixel_group", exp_g.pixel_group, result_o.pixel_group);
        check_field("row_in_band", 64'(exp_g.row_in_band), 64'(result_o.row_in_band));
        check_field("group_in_row", 64'(exp_g.group_in_row), 64'(result_o.group_in_row));
        check_field("band_done", 64'(exp_g.band_done), 64'(result_o.band_done));
        check_field("image_done", 64'(exp_g.image_done), 64'(result_o.image_done));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("planar_tile_band_to_raster_core_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    start        = 1'b0;
    item_i       = '0;
    rst_ni       = 1'b0;
    band_fill    = 0;
    fail_count   = 0;
    stall_cycles = 0;
    idle_pct     = 25;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_byte();
    test_partial_tile();
    test_tile_then_restart();
    test_random_bands(35);

    idle_pct = 76;
    test_random_bands(35);

    idle_pct = 0;
    test_random_bands(35);

    drain_groups();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_groups.size() == 0) begin
      $display("planar_tile_band_to_raster_core_test: PASS");
    end else begin
      $display("planar_tile_band_to_raster_core_test: FAIL");
    end
    $finish;
  end

endmodule
